>>> sv/mcgs_pkg.sv
// shared types and constants of the max cqi grant scheduler
`default_nettype none

package mcgs_pkg;

	localparam int ID_W    = 16;
	localparam int QUAL_W  = 4;
	localparam int BUF_W   = 24;
	localparam int SIZE_W  = 17;
	localparam int MODE_W  = 2;
	localparam int SLOT_W  = 4;
	localparam int GRANT_W = 5;

	localparam logic [MODE_W-1:0] MODE_USER  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TABLE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RUN   = 2'd2;

	localparam logic [GRANT_W-1:0] MAX_GRANTS_RST = 5'd4;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [QUAL_W-1:0] quality;
		logic [BUF_W-1:0]  buffer;
	} user_entry_t;

	// controller to datapath
	typedef struct packed {
		logic tti_start;
		logic wr_user;
		logic wr_table;
		logic ptr_clr;
		logic ptr_inc;
		logic scan_clr;
		logic scan_rd;
		logic out_rd;
		logic grant;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ptr_last;
		logic best_found;
		logic grants_done;
		logic out_fire;
	} sts_t;

endpackage

`default_nettype wire

>>> sv/mcgs_ctrl.sv
// controller state machine of the max cqi grant scheduler
`default_nettype none

module mcgs_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [mcgs_pkg::MODE_W-1:0]  mode,
	input  wire mcgs_pkg::sts_t               sts,
	output mcgs_pkg::cmd_t                    cmd
);
	import mcgs_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_CHECK    = 8'b0000_0010,
		ST_SCAN     = 8'b0000_0100,
		ST_SCAN_END = 8'b0000_1000,
		ST_DECIDE   = 8'b0001_0000,
		ST_OUT_RD   = 8'b0010_0000,
		ST_OUT_LD   = 8'b0100_0000,
		ST_OUT_WAIT = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (mode)
						MODE_USER: cmd.wr_user = 1'b1;
						MODE_TABLE: cmd.wr_table = 1'b1;
						MODE_RUN: begin
							cmd.tti_start = 1'b1;
							state_d       = ST_CHECK;
						end
						default: ;
					endcase
				end
			end
			ST_CHECK: begin
				cmd.ptr_clr = 1'b1;
				if (sts.grants_done) begin
					state_d = ST_OUT_RD;
				end else begin
					cmd.scan_clr = 1'b1;
					state_d      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				cmd.ptr_inc = 1'b1;
				if (sts.ptr_last) begin
					state_d = ST_SCAN_END;
				end
			end
			// last read of the scan is compared here
			ST_SCAN_END: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (sts.best_found) begin
					cmd.grant = 1'b1;
					state_d   = ST_CHECK;
				end else begin
					cmd.ptr_clr = 1'b1;
					state_d     = ST_OUT_RD;
				end
			end
			ST_OUT_RD: begin
				cmd.out_rd = 1'b1;
				state_d    = ST_OUT_LD;
			end
			ST_OUT_LD: begin
				cmd.out_load = 1'b1;
				state_d      = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				if (sts.out_fire) begin
					if (sts.ptr_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.ptr_inc = 1'b1;
						state_d     = ST_OUT_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> sv/mcgs_dp.sv
// datapath of the max cqi grant scheduler: user memory, size table, scan and result register
`default_nettype none

module mcgs_dp #(
	parameter int NUM_USERS      = 16,
	parameter int QUALITY_LEVELS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mcgs_pkg::cmd_t                cmd,
	output mcgs_pkg::sts_t                     sts,
	input  wire logic                          cfg_valid,
	input  wire logic [mcgs_pkg::GRANT_W-1:0]  cfg_data,
	input  wire logic [mcgs_pkg::SLOT_W-1:0]   user_index,
	input  wire logic [mcgs_pkg::ID_W-1:0]     user_id,
	input  wire logic [mcgs_pkg::QUAL_W-1:0]   quality,
	input  wire logic [mcgs_pkg::BUF_W-1:0]    buffer_amount,
	input  wire logic [mcgs_pkg::SIZE_W-1:0]   entry_size,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic [mcgs_pkg::SLOT_W-1:0]        out_index,
	output logic [mcgs_pkg::ID_W-1:0]          out_id,
	output logic [mcgs_pkg::SIZE_W-1:0]        grant_size,
	output logic                               last
);
	import mcgs_pkg::*;

	localparam int IDX_W = $clog2(NUM_USERS);
	localparam int QW    = $clog2(QUALITY_LEVELS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_USERS - 1);

	user_entry_t          user_mem [NUM_USERS];
	logic [NUM_USERS-1:0] user_vld_q;
	logic [NUM_USERS-1:0] mark_q;
	logic [NUM_USERS-1:0] granted_q;
	logic [SIZE_W-1:0]    size_tab_q [QUALITY_LEVELS];
	logic [GRANT_W-1:0]   max_grants_q;
	logic [GRANT_W-1:0]   count_q;
	logic [IDX_W-1:0]     ptr_q;

	user_entry_t          rd_data_s1;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic                 scan_v_s1;

	logic                 best_found_q;
	logic [IDX_W-1:0]     best_idx_q;
	user_entry_t          best_entry_q;

	logic                 out_valid_q;
	logic [SLOT_W-1:0]    out_idx_q;
	logic [ID_W-1:0]      out_id_q;
	logic [SIZE_W-1:0]    out_size_q;
	logic                 out_last_q;

	user_entry_t          rd_entry;
	user_entry_t          wr_data;
	logic [IDX_W-1:0]     wr_addr;
	logic                 mem_we;
	logic                 usr_we;
	logic                 tab_we;
	logic                 rd_en;
	logic                 cand;
	logic [QUAL_W-1:0]    lk_q;
	logic [SIZE_W-1:0]    lk_size;
	logic [BUF_W-1:0]     new_buf;
	logic                 out_fire;

	assign usr_we   = cmd.wr_user && (int'(user_index) < NUM_USERS);
	assign tab_we   = cmd.wr_table && (int'(quality) < QUALITY_LEVELS);
	assign rd_en    = cmd.scan_rd || cmd.out_rd;
	assign out_fire = out_valid_q && out_ready;

	// slots never written read as zero
	assign rd_entry = rd_vld_s1 ? rd_data_s1 : '0;

	assign cand = scan_v_s1 && !mark_q[rd_idx_s1] && (rd_entry.buffer != '0) &&
		(!best_found_q || (rd_entry.quality > best_entry_q.quality));

	// one table port, shared by the grant step and the result load
	assign lk_q    = cmd.out_load ? rd_entry.quality : best_entry_q.quality;
	assign lk_size = (int'(lk_q) < QUALITY_LEVELS) ? size_tab_q[QW'(lk_q)] : '0;
	assign new_buf = (BUF_W'(lk_size) >= best_entry_q.buffer) ? '0
		: best_entry_q.buffer - BUF_W'(lk_size);

	always_comb begin
		if (cmd.grant) begin
			wr_addr        = best_idx_q;
			wr_data        = best_entry_q;
			wr_data.buffer = new_buf;
			mem_we         = (lk_size != '0);
		end else begin
			wr_addr = IDX_W'(user_index);
			wr_data = '{id: user_id, quality: quality, buffer: buffer_amount};
			mem_we  = usr_we;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			user_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= user_mem[ptr_q];
			rd_idx_s1  <= ptr_q;
		end
		if (cand) begin
			best_idx_q   <= rd_idx_s1;
			best_entry_q <= rd_entry;
		end
		if (cmd.out_load) begin
			out_idx_q  <= SLOT_W'(rd_idx_s1);
			out_id_q   <= rd_entry.id;
			out_size_q <= granted_q[rd_idx_s1] ? lk_size : '0;
			out_last_q <= (rd_idx_s1 == LAST_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_vld_q   <= '0;
			mark_q       <= '0;
			granted_q    <= '0;
			max_grants_q <= MAX_GRANTS_RST;
			count_q      <= '0;
			ptr_q        <= '0;
			rd_vld_s1    <= 1'b0;
			scan_v_s1    <= 1'b0;
			best_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int k = 0; k < QUALITY_LEVELS; k++) begin
				size_tab_q[k] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				max_grants_q <= cfg_data;
			end
			if (usr_we) begin
				user_vld_q[IDX_W'(user_index)] <= 1'b1;
			end
			if (tab_we) begin
				size_tab_q[QW'(quality)] <= entry_size;
			end
			if (rd_en) begin
				rd_vld_s1 <= user_vld_q[ptr_q];
			end
			scan_v_s1 <= cmd.scan_rd;

			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + 1'b1;
			end

			if (cmd.scan_clr) begin
				best_found_q <= 1'b0;
			end else if (cand) begin
				best_found_q <= 1'b1;
			end

			if (cmd.tti_start) begin
				mark_q    <= '0;
				granted_q <= '0;
				count_q   <= '0;
			end else if (cmd.grant) begin
				// zero size marks the user but counts no grant
				mark_q[best_idx_q] <= 1'b1;
				if (lk_size != '0) begin
					granted_q[best_idx_q] <= 1'b1;
					count_q               <= count_q + 1'b1;
				end
			end

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.ptr_last    = (ptr_q == LAST_IDX);
	assign sts.best_found  = best_found_q;
	assign sts.grants_done = (count_q >= max_grants_q);
	assign sts.out_fire    = out_fire;

	assign out_valid  = out_valid_q;
	assign out_index  = out_idx_q;
	assign out_id     = out_id_q;
	assign grant_size = out_size_q;
	assign last       = out_last_q;

endmodule

`default_nettype wire

>>> sv/max_cqi_grant_scheduler.sv
// a tti scans all users once per pick and stops when the grant limit is met or no user is left;
// it then returns one result per user slot, in slot order
// results leave one at a time, each slot read only after the last result is taken; one transaction at a time
// reset: max_grants returns to 4, all user reports and table sizes read as zero,
// the controller goes idle and no result is pending
// top level of the max cqi grant scheduler
`default_nettype none

module max_cqi_grant_scheduler #(
	parameter int NUM_USERS      = 16,
	parameter int QUALITY_LEVELS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [mcgs_pkg::MODE_W-1:0]   mode,
	input  wire logic [mcgs_pkg::SLOT_W-1:0]   user_index,
	input  wire logic [mcgs_pkg::ID_W-1:0]     user_id,
	input  wire logic [mcgs_pkg::QUAL_W-1:0]   quality,
	input  wire logic [mcgs_pkg::BUF_W-1:0]    buffer_amount,
	input  wire logic [mcgs_pkg::SIZE_W-1:0]   entry_size,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [mcgs_pkg::SLOT_W-1:0]        out_index,
	output logic [mcgs_pkg::ID_W-1:0]          out_id,
	output logic [mcgs_pkg::SIZE_W-1:0]        grant_size,
	output logic                               last,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [mcgs_pkg::GRANT_W-1:0]  cfg_data
);
	import mcgs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// register writes are always accepted
	assign cfg_ready = 1'b1;

	mcgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.sts      (sts),
		.cmd      (cmd)
	);

	mcgs_dp #(
		.NUM_USERS      (NUM_USERS),
		.QUALITY_LEVELS (QUALITY_LEVELS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.user_index    (user_index),
		.user_id       (user_id),
		.quality       (quality),
		.buffer_amount (buffer_amount),
		.entry_size    (entry_size),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.out_index     (out_index),
		.out_id        (out_id),
		.grant_size    (grant_size),
		.last          (last)
	);

endmodule

`default_nettype wire

>>> test/max_cqi_grant_scheduler_checker.sv
// checker for the grant scheduler: watches all channels, predicts per-user grants, compares
module max_cqi_grant_scheduler_checker #(
	parameter int NUM_USERS      = 16,
	parameter int QUALITY_LEVELS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire logic [mcgs_pkg::MODE_W-1:0]   mode,
	input  wire logic [mcgs_pkg::SLOT_W-1:0]   user_index,
	input  wire logic [mcgs_pkg::ID_W-1:0]     user_id,
	input  wire logic [mcgs_pkg::QUAL_W-1:0]   quality,
	input  wire logic [mcgs_pkg::BUF_W-1:0]    buffer_amount,
	input  wire logic [mcgs_pkg::SIZE_W-1:0]   entry_size,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic [mcgs_pkg::SLOT_W-1:0]   out_index,
	input  wire logic [mcgs_pkg::ID_W-1:0]     out_id,
	input  wire logic [mcgs_pkg::SIZE_W-1:0]   grant_size,
	input  wire logic                          last,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [mcgs_pkg::GRANT_W-1:0]  cfg_data,
	output int                                 mismatches,
	output int                                 pending,
	output int                                 checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import mcgs_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   id;
		logic [SIZE_W-1:0] size;
		logic              last;
	} grant_result_t;

	grant_result_t      expected_grants[$];
	logic [ID_W-1:0]    slot_id [NUM_USERS];
	logic [QUAL_W-1:0]  slot_quality [NUM_USERS];
	logic [BUF_W-1:0]   slot_buffer [NUM_USERS];
	logic [SIZE_W-1:0]  size_by_quality [QUALITY_LEVELS];
	logic [GRANT_W-1:0] grant_limit;

	// one tti: greedy picks by quality, lowest slot on ties, then one result per slot
	task automatic schedule_tti();
		logic [SIZE_W-1:0] granted [NUM_USERS];
		bit                marked [NUM_USERS];
		int                counted;
		int                best;
		logic [SIZE_W-1:0] sz;
		grant_result_t     r;
		for (int i = 0; i < NUM_USERS; i++) begin
			granted[i] = '0;
			marked[i] = 1'b0;
		end
		counted = 0;
		while (counted < grant_limit) begin
			best = -1;
			for (int i = 0; i < NUM_USERS; i++)
				if (!marked[i] && slot_buffer[i] != '0 &&
						(best < 0 || slot_quality[i] > slot_quality[best]))
					best = i;
			if (best < 0)
				break;
			sz = (slot_quality[best] < QUALITY_LEVELS) ? size_by_quality[slot_quality[best]] : '0;
			marked[best] = 1'b1;
			// unusable quality marks the user but does not use up a grant
			if (sz != '0) begin
				granted[best] = sz;
				slot_buffer[best] = (sz >= slot_buffer[best]) ? '0 : slot_buffer[best] - sz;
				counted++;
			end
		end
		for (int i = 0; i < NUM_USERS; i++) begin
			r.slot = SLOT_W'(i);
			r.id = slot_id[i];
			r.size = granted[i];
			r.last = (i == NUM_USERS - 1);
			expected_grants.push_back(r);
		end
	endtask

	task automatic apply_request();
		case (mode)
			MODE_USER: begin
				if (user_index < NUM_USERS) begin
					slot_id[user_index] = user_id;
					slot_quality[user_index] = quality;
					slot_buffer[user_index] = buffer_amount;
				end
			end
			MODE_TABLE: begin
				if (quality < QUALITY_LEVELS)
					size_by_quality[quality] = entry_size;
			end
			MODE_RUN: begin
				schedule_tti();
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_result_t got;
		grant_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_USERS; i++) begin
				slot_id[i] = '0;
				slot_quality[i] = '0;
				slot_buffer[i] = '0;
			end
			for (int i = 0; i < QUALITY_LEVELS; i++)
				size_by_quality[i] = '0;
			grant_limit = MAX_GRANTS_RST;
			expected_grants.delete();
			mismatches = 0;
			pending = 0;
			checked = 0;
		end else begin
			// results leaving now belong to earlier requests, so compare first
			if (out_valid && out_ready) begin
				got.slot = out_index;
				got.id = out_id;
				got.size = grant_size;
				got.last = last;
				if (expected_grants.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result: slot %0d id %0h size %0d last %0b",
							$realtime, got.slot, got.id, got.size, got.last);
				end else begin
					want = expected_grants.pop_front();
					checked++;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: grant result wrong: exp slot %0d id %0h size %0d last %0b",
								$realtime, want.slot, want.id, want.size, want.last);
							$display("    got slot %0d id %0h size %0d last %0b",
								got.slot, got.id, got.size, got.last);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready)
				grant_limit = cfg_data;
			if (in_valid && in_ready)
				apply_request();
			pending = expected_grants.size();
		end
	end

endmodule

>>> test/max_cqi_grant_scheduler_tb.sv
// testbench top for the max cqi grant scheduler: clock, reset, stimulus and verdict
module max_cqi_grant_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mcgs_pkg::*;

	localparam int USERS        = 16;
	localparam int LEVELS       = 16;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS  = 22;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [MODE_W-1:0]  mode;
	logic [SLOT_W-1:0]  user_index;
	logic [ID_W-1:0]    user_id;
	logic [QUAL_W-1:0]  quality;
	logic [BUF_W-1:0]   buffer_amount;
	logic [SIZE_W-1:0]  entry_size;
	logic               out_valid;
	logic               out_ready;
	logic [SLOT_W-1:0]  out_index;
	logic [ID_W-1:0]    out_id;
	logic [SIZE_W-1:0]  grant_size;
	logic               last;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [GRANT_W-1:0] cfg_data;

	int mismatches;
	int pending;
	int checked;
	int sender_idle_pct;
	int stall_pct;
	int quiet_cycles;
	int requests_sent;
	int tti_runs;
	int limit_writes;

	max_cqi_grant_scheduler #(
		.NUM_USERS(USERS),
		.QUALITY_LEVELS(LEVELS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.user_index(user_index),
		.user_id(user_id),
		.quality(quality),
		.buffer_amount(buffer_amount),
		.entry_size(entry_size),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_index(out_index),
		.out_id(out_id),
		.grant_size(grant_size),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	max_cqi_grant_scheduler_checker #(
		.NUM_USERS(USERS),
		.QUALITY_LEVELS(LEVELS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.user_index(user_index),
		.user_id(user_id),
		.quality(quality),
		.buffer_amount(buffer_amount),
		.entry_size(entry_size),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_index(out_index),
		.out_id(out_id),
		.grant_size(grant_size),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending),
		.checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= stall_pct);
	end

	// no transaction on any channel for too long means the block is stuck
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// called and returns at a falling edge; valid stays up if the next request follows at once
	task automatic offer_request(input logic [MODE_W-1:0] m, input logic [SLOT_W-1:0] slot,
			input logic [ID_W-1:0] id, input logic [QUAL_W-1:0] q,
			input logic [BUF_W-1:0] amount, input logic [SIZE_W-1:0] sz);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		mode = m;
		user_index = slot;
		user_id = id;
		quality = q;
		buffer_amount = amount;
		entry_size = sz;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		requests_sent++;
		if (m == MODE_RUN)
			tti_runs++;
		@(negedge clk);
	endtask

	task automatic write_grant_limit(input logic [GRANT_W-1:0] value);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		// table and report writes give no result, so let the block settle
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		limit_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic offer_random_request();
		int                pick;
		logic [MODE_W-1:0] m;
		logic [BUF_W-1:0]  amount;
		logic [SIZE_W-1:0] sz;
		pick = $urandom_range(99);
		if (pick < 48)
			m = MODE_USER;
		else if (pick < 68)
			m = MODE_TABLE;
		else if (pick < 93)
			m = MODE_RUN;
		else
			m = MODE_SPARE;
		case ($urandom_range(9))
			0: amount = '0;
			1: amount = '1;
			2: amount = BUF_W'($urandom);
			default: amount = BUF_W'($urandom_range(1, 20000));
		endcase
		case ($urandom_range(9))
			0, 1: sz = '0;
			2: sz = '1;
			3: sz = SIZE_W'($urandom);
			default: sz = SIZE_W'($urandom_range(1, 8000));
		endcase
		offer_request(m, SLOT_W'($urandom), ID_W'($urandom), QUAL_W'($urandom), amount, sz);
	endtask

	initial begin
		int phase_idle [4];
		int phase_stall [4];
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_USER;
		user_index = '0;
		user_id = '0;
		quality = '0;
		buffer_amount = '0;
		entry_size = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		sender_idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		requests_sent = 0;
		tti_runs = 0;
		limit_writes = 0;
		phase_idle = '{0, 66, 0, 20};
		phase_stall = '{0, 0, 66, 20};
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty tti out of reset, then a crafted population
		offer_request(MODE_RUN, '0, '0, '0, '0, '0);
		offer_request(MODE_TABLE, '0, '0, 4'd15, '0, '1);
		offer_request(MODE_TABLE, '0, '0, 4'd7, '0, '0);
		offer_request(MODE_TABLE, '0, '0, 4'd3, '0, 17'd100);
		offer_request(MODE_TABLE, '0, '0, 4'd0, '0, 17'd1);
		offer_request(MODE_USER, 4'd0, '1, 4'd15, '1, '0);
		offer_request(MODE_USER, 4'd15, 16'hA5A5, 4'd3, 24'd50, '0);
		offer_request(MODE_USER, 4'd5, 16'h5A5A, 4'd3, 24'd1000, '0);
		offer_request(MODE_USER, 4'd7, 16'h0707, 4'd7, 24'd500, '0);
		offer_request(MODE_USER, 4'd9, 16'h0909, 4'd0, 24'd1, '0);
		// top quality but nothing buffered: never eligible
		offer_request(MODE_USER, 4'd3, 16'h0303, 4'd15, '0, '1);
		offer_request(MODE_SPARE, '1, '1, '1, '1, '1);
		offer_request(MODE_RUN, '0, '0, '0, '0, '0);
		offer_request(MODE_RUN, '1, '1, '1, '1, '1);
		write_grant_limit('0);
		offer_request(MODE_RUN, '0, '0, '0, '0, '0);
		write_grant_limit('1);
		offer_request(MODE_USER, 4'd12, 16'h1234, 4'd3, 24'd150, '0);
		offer_request(MODE_RUN, '0, '0, '0, '0, '0);
		offer_request(MODE_RUN, '0, '0, '0, '0, '0);
		write_grant_limit(5'd1);
		offer_request(MODE_USER, 4'd0, 16'hFFFE, 4'd15, 24'd131071, '0);
		offer_request(MODE_RUN, '0, '0, '0, '0, '0);
		offer_request(MODE_RUN, '0, '0, '0, '0, '0);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: write_grant_limit(5'd16);
				1: write_grant_limit(GRANT_W'($urandom_range(1, 16)));
				2: write_grant_limit('1);
				default: write_grant_limit(GRANT_W'($urandom_range(0, 31)));
			endcase
			sender_idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			repeat (PHASE_ITEMS) offer_random_request();
		end
		in_valid = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("run covered %0d requests with %0d tti runs and %0d grant limit writes",
			requests_sent, tti_runs, limit_writes);
		$display("%0d per-user grant results compared across four idle/stall mixes", checked);
		if (mismatches == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
